### rtl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Result beat layout, run record, token/group/error codes and word tables.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 2;
    localparam int TK_W    = 6;
    localparam int GRP_W   = 4;
    localparam int START_W = 24;
    localparam int LINE_W  = 20;
    localparam int LEN_W   = 16;
    localparam int ERR_W   = 3;

    localparam int QUEUE_DEPTH = 4;

    // result kinds
    localparam logic [KIND_W-1:0] RK_TOKEN = 2'd0;
    localparam logic [KIND_W-1:0] RK_ERROR = 2'd1;
    localparam logic [KIND_W-1:0] RK_DONE  = 2'd2;

    // token kinds
    localparam logic [TK_W-1:0] TK_IF         = 6'd0;
    localparam logic [TK_W-1:0] TK_FOR        = 6'd1;
    localparam logic [TK_W-1:0] TK_WHILE      = 6'd2;
    localparam logic [TK_W-1:0] TK_ELSE       = 6'd3;
    localparam logic [TK_W-1:0] TK_RETURN     = 6'd4;
    localparam logic [TK_W-1:0] TK_CONTINUE   = 6'd5;
    localparam logic [TK_W-1:0] TK_BREAK      = 6'd6;
    localparam logic [TK_W-1:0] TK_IDENT      = 6'd7;
    localparam logic [TK_W-1:0] TK_ADD_ASSIGN = 6'd8;
    localparam logic [TK_W-1:0] TK_PLUS       = 6'd9;
    localparam logic [TK_W-1:0] TK_INCR       = 6'd10;
    localparam logic [TK_W-1:0] TK_INT_LIT    = 6'd11;
    localparam logic [TK_W-1:0] TK_FLOAT_LIT  = 6'd12;
    localparam logic [TK_W-1:0] TK_SUB_ASSIGN = 6'd13;
    localparam logic [TK_W-1:0] TK_DECR       = 6'd14;
    localparam logic [TK_W-1:0] TK_MINUS      = 6'd15;
    localparam logic [TK_W-1:0] TK_GT         = 6'd16;
    localparam logic [TK_W-1:0] TK_GE         = 6'd17;
    localparam logic [TK_W-1:0] TK_LT         = 6'd18;
    localparam logic [TK_W-1:0] TK_LE         = 6'd19;
    localparam logic [TK_W-1:0] TK_STAR       = 6'd20;
    localparam logic [TK_W-1:0] TK_MUL_ASSIGN = 6'd21;
    localparam logic [TK_W-1:0] TK_POWER      = 6'd22;
    localparam logic [TK_W-1:0] TK_SLASH      = 6'd23;
    localparam logic [TK_W-1:0] TK_DIV_ASSIGN = 6'd24;
    localparam logic [TK_W-1:0] TK_DSLASH     = 6'd25;
    localparam logic [TK_W-1:0] TK_STR_LIT    = 6'd26;
    localparam logic [TK_W-1:0] TK_CHR_LIT    = 6'd27;
    localparam logic [TK_W-1:0] TK_LPAREN     = 6'd28;
    localparam logic [TK_W-1:0] TK_RPAREN     = 6'd29;
    localparam logic [TK_W-1:0] TK_LBRACE     = 6'd30;
    localparam logic [TK_W-1:0] TK_RBRACE     = 6'd31;
    localparam logic [TK_W-1:0] TK_RBRACK     = 6'd32;
    localparam logic [TK_W-1:0] TK_LBRACK     = 6'd33;
    localparam logic [TK_W-1:0] TK_ASSIGN     = 6'd34;
    localparam logic [TK_W-1:0] TK_DOT        = 6'd35;
    localparam logic [TK_W-1:0] TK_PERCENT    = 6'd36;
    localparam logic [TK_W-1:0] TK_SEMI       = 6'd37;
    localparam logic [TK_W-1:0] TK_COLON      = 6'd38;
    localparam logic [TK_W-1:0] TK_PROGRAM    = 6'd39;
    localparam logic [TK_W-1:0] TK_MODULE     = 6'd40;
    localparam logic [TK_W-1:0] TK_USING      = 6'd41;
    localparam logic [TK_W-1:0] TK_MACRO      = 6'd42;
    localparam logic [TK_W-1:0] TK_END        = 6'd43;
    localparam logic [TK_W-1:0] TK_COMMA      = 6'd44;

    // token groups
    localparam logic [GRP_W-1:0] GRP_KEYWORD  = 4'd0;
    localparam logic [GRP_W-1:0] GRP_NAME     = 4'd1;
    localparam logic [GRP_W-1:0] GRP_ASSIGN   = 4'd2;
    localparam logic [GRP_W-1:0] GRP_BINOP    = 4'd3;
    localparam logic [GRP_W-1:0] GRP_UNOP     = 4'd4;
    localparam logic [GRP_W-1:0] GRP_LITERAL  = 4'd5;
    localparam logic [GRP_W-1:0] GRP_RELOP    = 4'd6;
    localparam logic [GRP_W-1:0] GRP_BRACKET  = 4'd7;
    localparam logic [GRP_W-1:0] GRP_PUNCT    = 4'd8;
    localparam logic [GRP_W-1:0] GRP_DIR_MAIN = 4'd9;
    localparam logic [GRP_W-1:0] GRP_DIR_AUX  = 4'd10;

    // error kinds
    localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY_CHR = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_ESC   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_CLOSE = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_DIR   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_UNTERM    = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TK_W-1:0]    tk;
        logic [GRP_W-1:0]   grp;
        logic [START_W-1:0] start;
        logic [LINE_W-1:0]  line_no;
        logic [LEN_W-1:0]   len;
        logic               sym;
        logic [ERR_W-1:0]   ek;
    } t_result;

    // all results caused by one byte
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_run;

    // fixed words, left aligned, first byte in the top byte
    localparam int WORD_BYTES = 8;
    localparam int NUM_KEYWORDS = 7;
    localparam int NUM_DIRECTIVES = 5;

    typedef struct packed {
        logic [3:0]              len;
        logic [8*WORD_BYTES-1:0] text;
        logic [TK_W-1:0]         kind;
        logic [GRP_W-1:0]        grp;
    } t_word;

    localparam t_word KEYWORDS [NUM_KEYWORDS] = '{
        '{4'd2, {"if", 48'h0},     TK_IF,       GRP_KEYWORD},
        '{4'd3, {"for", 40'h0},    TK_FOR,      GRP_KEYWORD},
        '{4'd5, {"while", 24'h0},  TK_WHILE,    GRP_KEYWORD},
        '{4'd4, {"else", 32'h0},   TK_ELSE,     GRP_KEYWORD},
        '{4'd6, {"return", 16'h0}, TK_RETURN,   GRP_KEYWORD},
        '{4'd8, {"continue"},      TK_CONTINUE, GRP_KEYWORD},
        '{4'd5, {"break", 24'h0},  TK_BREAK,    GRP_KEYWORD}
    };

    localparam t_word DIRECTIVES [NUM_DIRECTIVES] = '{
        '{4'd8, {"#PROGRAM"},      TK_PROGRAM, GRP_DIR_MAIN},
        '{4'd7, {"#MODULE", 8'h0}, TK_MODULE,  GRP_DIR_MAIN},
        '{4'd6, {"#using", 16'h0}, TK_USING,   GRP_DIR_AUX},
        '{4'd6, {"#macro", 16'h0}, TK_MACRO,   GRP_DIR_AUX},
        '{4'd4, {"#END", 32'h0},   TK_END,     GRP_DIR_MAIN}
    };

    // byte mask covering the first len bytes of a left-aligned word
    function automatic logic [8*WORD_BYTES-1:0] word_mask(input logic [3:0] len);
        return ~({(8*WORD_BYTES){1'b1}} >> {len, 3'b000});
    endfunction

endpackage

### rtl/stt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_if: valid/ready channels of the source text tokenizer
// Byte input channel and result output channel.
// ----------------------------------------------------------------------------
interface stt_in_if;
    logic                       valid;
    logic                       ready;
    logic [stt_pkg::CHAR_W-1:0] next_char;

    modport source (output valid, output next_char, input ready);
    modport sink (input valid, input next_char, output ready);
endinterface

interface stt_out_if;
    logic                        valid;
    logic                        ready;
    logic [stt_pkg::KIND_W-1:0]  result_kind;
    logic [stt_pkg::TK_W-1:0]    token_kind;
    logic [stt_pkg::GRP_W-1:0]   token_group;
    logic [stt_pkg::START_W-1:0] start_offset;
    logic [stt_pkg::LINE_W-1:0]  line_number;
    logic [stt_pkg::LEN_W-1:0]   token_length;
    logic                        enter_symbol;
    logic [stt_pkg::ERR_W-1:0]   error_kind;
    logic                        last_of_run;

    modport source (
        output valid, output result_kind, output token_kind, output token_group,
        output start_offset, output line_number, output token_length,
        output enter_symbol, output error_kind, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input result_kind, input token_kind, input token_group,
        input start_offset, input line_number, input token_length,
        input enter_symbol, input error_kind, input last_of_run,
        output ready
    );
endinterface

### rtl/source_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer: byte-serial source lexer
// Lexer front end, run queue and result back end.
// ----------------------------------------------------------------------------
// Takes one source byte per beat and returns tokens, an error or an end-of-text
// beat. The lexer front end classifies every byte in the cycle it is accepted,
// so the input takes one byte per clock as long as the four-entry run queue has
// room. A byte causes zero, one or two results; the back end hands out one
// result per clock from its output register while the sink is ready, so a
// byte that closes a token by lookahead and also finishes a one-byte token,
// ends the text or raises an error gives two results, and the queue absorbs
// such bursts. Runs pass from the queue head into the output register.
// Results of one byte come back to back with last_of_run set on the final one.
// Keywords and directives are matched by a parallel compare against the first
// bytes of the open token held in a small word buffer. After an error or an
// end-of-text result the block keeps taking bytes but gives no more results
// until reset. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
    parameter int OFFSET_BITS       = 24,
    parameter int WORD_BUFFER_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stt_in_if.sink           i_in,
    stt_out_if.source        o_out
);
    import stt_pkg::*;

    logic    w_accept;
    logic    w_push;
    t_run    w_push_run;
    t_run    w_head;
    logic    w_head_valid;
    logic    w_full;
    logic    w_pop;
    logic    w_out_valid;
    t_result w_out_res;
    logic    w_out_last;

    // front is ready whenever the queue can take one more run
    assign i_in.ready = !w_full;
    assign w_accept   = i_in.valid && !w_full;

    stt_front #(
        .OFFSET_BITS       (OFFSET_BITS),
        .WORD_BUFFER_DEPTH (WORD_BUFFER_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (i_in.next_char),
        .o_push   (w_push),
        .o_run    (w_push_run)
    );

    stt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_run   (w_push_run),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .o_full       (w_full)
    );

    stt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_valid      (w_out_valid),
        .i_ready      (o_out.ready),
        .o_res        (w_out_res),
        .o_last       (w_out_last)
    );

    assign o_out.valid        = w_out_valid;
    assign o_out.result_kind  = w_out_res.kind;
    assign o_out.token_kind   = w_out_res.tk;
    assign o_out.token_group  = w_out_res.grp;
    assign o_out.start_offset = w_out_res.start;
    assign o_out.line_number  = w_out_res.line_no;
    assign o_out.token_length = w_out_res.len;
    assign o_out.enter_symbol = w_out_res.sym;
    assign o_out.error_kind   = w_out_res.ek;
    assign o_out.last_of_run  = w_out_last;

    // an error or end-of-text beat is the very last beat before reset
    a_stop_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.result_kind != RK_TOKEN |=> !o_out.valid)
        else $error("result beat after error or end of text");

    // only a closed token can be followed by a second result of the same byte
    a_pair_head_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.last_of_run |-> o_out.result_kind == RK_TOKEN)
        else $error("non-token result opens a two-result run");

    // second result of a run follows right after the first without a gap
    a_pair_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_of_run |=>
            o_out.valid && o_out.last_of_run)
        else $error("second result of a run missing");

endmodule

### rtl/stt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_queue: run queue between lexer front and result back end
// Small register FIFO of per-byte run records.
// ----------------------------------------------------------------------------
module stt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stt_pkg::t_run i_push_run,
    input  logic          i_pop,
    output stt_pkg::t_run o_head,
    output logic          o_head_valid,
    output logic          o_full
);
    import stt_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_run          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_head       = r_mem[r_rd];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_run;
        end
    end

endmodule

### rtl/stt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_front: lexer state machine
// Classifies one byte per beat and builds the run of results it causes.
// ----------------------------------------------------------------------------
module stt_front #(
    parameter int OFFSET_BITS       = 24,
    parameter int WORD_BUFFER_DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [stt_pkg::CHAR_W-1:0] i_char,
    output logic                       o_push,
    output stt_pkg::t_run              o_run
);
    import stt_pkg::*;

    localparam int IW = $clog2(WORD_BUFFER_DEPTH);
    localparam int LW = (OFFSET_BITS + 1 > 17) ? OFFSET_BITS + 1 : 17;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_IDENT    = 4'd1;
    localparam logic [3:0] S_PLUS     = 4'd2;
    localparam logic [3:0] S_MINUS    = 4'd3;
    localparam logic [3:0] S_STR      = 4'd4;
    localparam logic [3:0] S_STR_ESC  = 4'd5;
    localparam logic [3:0] S_DIRECT   = 4'd6;
    localparam logic [3:0] S_CHR_OPEN = 4'd7;
    localparam logic [3:0] S_CHR_ESC  = 4'd8;
    localparam logic [3:0] S_CHR_BODY = 4'd9;
    localparam logic [3:0] S_INT      = 4'd10;
    localparam logic [3:0] S_FLOAT    = 4'd11;
    localparam logic [3:0] S_GT       = 4'd12;
    localparam logic [3:0] S_LT       = 4'd13;
    localparam logic [3:0] S_STAR     = 4'd14;
    localparam logic [3:0] S_SLASH    = 4'd15;

    logic [3:0]              r_state;
    logic [3:0]              n_state;
    logic [OFFSET_BITS-1:0]  r_offset;
    logic [OFFSET_BITS-1:0]  r_start;
    logic [LINE_W-1:0]       r_line;
    logic                    r_halted;
    logic [CHAR_W-1:0]       r_wbuf [WORD_BUFFER_DEPTH];

    logic [OFFSET_BITS-1:0]  w_delta;
    logic [OFFSET_BITS-1:0]  w_delta_m1;
    logic [LEN_W-1:0]        w_len_here;
    logic [LEN_W-1:0]        w_len_prev;
    logic [START_W-1:0]      w_here24;
    logic [START_W-1:0]      w_start24;
    logic [8*WORD_BYTES-1:0] w_lead;
    logic [TK_W-1:0]         w_kw_tk;
    logic [GRP_W-1:0]        w_kw_grp;
    logic [TK_W-1:0]         w_dir_tk;
    logic [GRP_W-1:0]        w_dir_grp;
    logic                    w_dir_hit;
    logic                    w_alpha;
    logic                    w_digit;

    logic                    w_back;
    logic                    w_keep;
    logic                    w_idle;
    logic                    w_p1_emit;
    logic                    w_idle_emit;
    logic                    w_stop;
    t_result                 w_back_res;
    t_result                 w_p1_res;
    t_result                 w_idle_res;

    function automatic logic [LEN_W-1:0] sat_len(input logic [OFFSET_BITS:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        return (w > LW'(17'h0FFFF)) ? {LEN_W{1'b1}} : w[LEN_W-1:0];
    endfunction

    function automatic t_result mk_tok(
        input logic [TK_W-1:0]    tk,
        input logic [GRP_W-1:0]   grp,
        input logic [START_W-1:0] start,
        input logic [LINE_W-1:0]  line_no,
        input logic [LEN_W-1:0]   len
    );
        t_result r;
        r.kind    = RK_TOKEN;
        r.tk      = tk;
        r.grp     = grp;
        r.start   = start;
        r.line_no = line_no;
        r.len     = len;
        r.sym     = (tk == TK_IDENT) || (grp == GRP_LITERAL);
        r.ek      = '0;
        return r;
    endfunction

    function automatic t_result mk_err(
        input logic [ERR_W-1:0]   ek,
        input logic [START_W-1:0] start,
        input logic [LINE_W-1:0]  line_no,
        input logic [LEN_W-1:0]   len
    );
        t_result r;
        r         = '0;
        r.kind    = RK_ERROR;
        r.start   = start;
        r.line_no = line_no;
        r.len     = len;
        r.ek      = ek;
        return r;
    endfunction

    // distance from token start to this byte, and the two span lengths
    assign w_delta    = r_offset - r_start;
    assign w_delta_m1 = w_delta - OFFSET_BITS'(1);
    assign w_len_here = sat_len({1'b0, w_delta} + (OFFSET_BITS + 1)'(1));
    assign w_len_prev = sat_len({1'b0, w_delta_m1} + (OFFSET_BITS + 1)'(1));
    assign w_here24   = START_W'(r_offset);
    assign w_start24  = START_W'(r_start);

    assign w_alpha = (i_char inside {["a":"z"], ["A":"Z"]});
    assign w_digit = (i_char inside {["0":"9"]});

    // parallel compare of the word buffer against the fixed words
    always_comb begin
        for (int i = 0; i < WORD_BYTES; i++) begin
            w_lead[8*(WORD_BYTES-1-i) +: 8] = r_wbuf[i];
        end
        w_kw_tk   = TK_IDENT;
        w_kw_grp  = GRP_NAME;
        w_dir_tk  = TK_PROGRAM;
        w_dir_grp = GRP_DIR_MAIN;
        w_dir_hit = 1'b0;
        for (int i = 0; i < NUM_KEYWORDS; i++) begin
            if (w_delta == OFFSET_BITS'(KEYWORDS[i].len) &&
                ((w_lead ^ KEYWORDS[i].text) & word_mask(KEYWORDS[i].len)) == '0) begin
                w_kw_tk  = KEYWORDS[i].kind;
                w_kw_grp = KEYWORDS[i].grp;
            end
        end
        for (int i = 0; i < NUM_DIRECTIVES; i++) begin
            if (w_delta == OFFSET_BITS'(DIRECTIVES[i].len) &&
                ((w_lead ^ DIRECTIVES[i].text) & word_mask(DIRECTIVES[i].len)) == '0) begin
                w_dir_tk  = DIRECTIVES[i].kind;
                w_dir_grp = DIRECTIVES[i].grp;
                w_dir_hit = 1'b1;
            end
        end
    end

    // open-token states; a byte that ends a token by lookahead falls to idle
    always_comb begin
        logic [TK_W-1:0]  v_btk;
        logic [GRP_W-1:0] v_bgrp;
        logic             v_err;
        logic [ERR_W-1:0] v_ek;
        logic             v_tok;
        logic [TK_W-1:0]  v_tk;
        logic [GRP_W-1:0] v_grp;

        v_btk   = TK_IDENT;
        v_bgrp  = GRP_NAME;
        v_err   = 1'b0;
        v_ek    = ERR_UNTERM;
        v_tok   = 1'b0;
        v_tk    = TK_IDENT;
        v_grp   = GRP_NAME;
        w_back  = 1'b0;
        w_keep  = 1'b0;
        w_idle  = 1'b0;
        n_state = r_state;

        case (r_state)
            S_IDENT: begin
                if (w_alpha || w_digit || i_char == "_") begin
                    w_keep = 1'b1;
                end else begin
                    w_back = 1'b1;
                    v_btk  = w_kw_tk;
                    v_bgrp = w_kw_grp;
                end
            end
            S_PLUS: begin
                if (i_char == "=") begin
                    v_tok = 1'b1; v_tk = TK_ADD_ASSIGN; v_grp = GRP_ASSIGN;
                end else if (i_char == "+") begin
                    v_tok = 1'b1; v_tk = TK_INCR; v_grp = GRP_UNOP;
                end else if (w_digit) begin
                    w_keep = 1'b1; n_state = S_INT;
                end else begin
                    w_back = 1'b1; v_btk = TK_PLUS; v_bgrp = GRP_BINOP;
                end
            end
            S_MINUS: begin
                if (i_char == "-") begin
                    v_tok = 1'b1; v_tk = TK_DECR; v_grp = GRP_UNOP;
                end else if (i_char == "=") begin
                    v_tok = 1'b1; v_tk = TK_SUB_ASSIGN; v_grp = GRP_ASSIGN;
                end else if (w_digit) begin
                    w_keep = 1'b1; n_state = S_INT;
                end else begin
                    w_back = 1'b1; v_btk = TK_MINUS; v_bgrp = GRP_BINOP;
                end
            end
            S_STR: begin
                if (i_char == 8'h00) begin
                    v_err = 1'b1; v_ek = ERR_UNTERM;
                end else if (i_char == "\"") begin
                    v_tok = 1'b1; v_tk = TK_STR_LIT; v_grp = GRP_LITERAL;
                end else if (i_char == "\\") begin
                    n_state = S_STR_ESC;
                end
            end
            S_STR_ESC: begin
                if (i_char == 8'h00) begin
                    v_err = 1'b1; v_ek = ERR_UNTERM;
                end else begin
                    n_state = S_STR;
                end
            end
            S_DIRECT: begin
                if (w_alpha) begin
                    w_keep = 1'b1;
                end else if (w_dir_hit) begin
                    w_back = 1'b1; v_btk = w_dir_tk; v_bgrp = w_dir_grp;
                end else begin
                    v_err = 1'b1; v_ek = ERR_BAD_DIR;
                end
            end
            S_CHR_OPEN: begin
                if (i_char == 8'h00) begin
                    v_err = 1'b1; v_ek = ERR_UNTERM;
                end else if (i_char == "'") begin
                    v_err = 1'b1; v_ek = ERR_EMPTY_CHR;
                end else if (i_char == "\\") begin
                    n_state = S_CHR_ESC;
                end else begin
                    n_state = S_CHR_BODY;
                end
            end
            S_CHR_ESC: begin
                if (i_char == 8'h00) begin
                    v_err = 1'b1; v_ek = ERR_UNTERM;
                end else if (i_char inside {"n", "b", "t", "r", "f", "'", "\\"}) begin
                    n_state = S_CHR_BODY;
                end else begin
                    v_err = 1'b1; v_ek = ERR_BAD_ESC;
                end
            end
            S_CHR_BODY: begin
                if (i_char == 8'h00) begin
                    v_err = 1'b1; v_ek = ERR_UNTERM;
                end else if (i_char == "'") begin
                    v_tok = 1'b1; v_tk = TK_CHR_LIT; v_grp = GRP_LITERAL;
                end else begin
                    v_err = 1'b1; v_ek = ERR_BAD_CLOSE;
                end
            end
            S_INT: begin
                if (i_char == ".") begin
                    n_state = S_FLOAT;
                end else if (!w_digit) begin
                    w_back = 1'b1; v_btk = TK_INT_LIT; v_bgrp = GRP_LITERAL;
                end
            end
            S_FLOAT: begin
                if (!w_digit) begin
                    w_back = 1'b1; v_btk = TK_FLOAT_LIT; v_bgrp = GRP_LITERAL;
                end
            end
            S_GT: begin
                if (i_char == "=") begin
                    v_tok = 1'b1; v_tk = TK_GE; v_grp = GRP_RELOP;
                end else begin
                    w_back = 1'b1; v_btk = TK_GT; v_bgrp = GRP_RELOP;
                end
            end
            S_LT: begin
                if (i_char == "=") begin
                    v_tok = 1'b1; v_tk = TK_LE; v_grp = GRP_RELOP;
                end else begin
                    w_back = 1'b1; v_btk = TK_LT; v_bgrp = GRP_RELOP;
                end
            end
            S_STAR: begin
                if (i_char == "*") begin
                    v_tok = 1'b1; v_tk = TK_POWER; v_grp = GRP_BINOP;
                end else if (i_char == "=") begin
                    v_tok = 1'b1; v_tk = TK_MUL_ASSIGN; v_grp = GRP_ASSIGN;
                end else begin
                    w_back = 1'b1; v_btk = TK_STAR; v_bgrp = GRP_BINOP;
                end
            end
            S_SLASH: begin
                if (i_char == "/") begin
                    v_tok = 1'b1; v_tk = TK_DSLASH; v_grp = GRP_BINOP;
                end else if (i_char == "=") begin
                    v_tok = 1'b1; v_tk = TK_DIV_ASSIGN; v_grp = GRP_ASSIGN;
                end else begin
                    w_back = 1'b1; v_btk = TK_SLASH; v_bgrp = GRP_BINOP;
                end
            end
            default: begin
                w_idle = 1'b1;
            end
        endcase

        if (v_tok) begin
            n_state = S_IDLE;
        end
        if (w_back) begin
            w_idle = 1'b1;
        end

        w_p1_emit  = v_tok || v_err;
        w_back_res = mk_tok(v_btk, v_bgrp, w_start24, r_line, w_len_prev);
        if (v_err) begin
            w_p1_res = mk_err(v_ek, w_start24, r_line,
                              (v_ek == ERR_BAD_DIR) ? w_len_prev : w_len_here);
        end else begin
            w_p1_res = mk_tok(v_tk, v_grp, w_start24, r_line, w_len_here);
        end
        w_stop = v_err;

        // idle: start of a new token at this byte
        w_idle_emit = 1'b0;
        w_idle_res  = mk_tok(TK_IDENT, GRP_NAME, w_here24, r_line, LEN_W'(1));
        if (w_idle) begin
            n_state = S_IDLE;
            if (i_char == 8'h00) begin
                w_idle_emit        = 1'b1;
                w_stop             = 1'b1;
                w_idle_res         = '0;
                w_idle_res.kind    = RK_DONE;
                w_idle_res.start   = w_here24;
                w_idle_res.line_no = r_line;
            end else if (w_alpha || i_char == "_") begin
                n_state = S_IDENT;
            end else if (i_char == " " || i_char == "\t" || i_char == "\n") begin
                n_state = S_IDLE;
            end else if (i_char == "\"") begin
                n_state = S_STR;
            end else if (i_char == "'") begin
                n_state = S_CHR_OPEN;
            end else if (i_char == "+") begin
                n_state = S_PLUS;
            end else if (i_char == "-") begin
                n_state = S_MINUS;
            end else if (i_char == ">") begin
                n_state = S_GT;
            end else if (i_char == "<") begin
                n_state = S_LT;
            end else if (i_char == "*") begin
                n_state = S_STAR;
            end else if (i_char == "/") begin
                n_state = S_SLASH;
            end else if (w_digit) begin
                n_state = S_INT;
            end else if (i_char == "#") begin
                n_state = S_DIRECT;
            end else begin
                w_idle_emit = 1'b1;
                case (i_char)
                    "(": begin
                        w_idle_res.tk = TK_LPAREN;  w_idle_res.grp = GRP_BRACKET;
                    end
                    ")": begin
                        w_idle_res.tk = TK_RPAREN;  w_idle_res.grp = GRP_BRACKET;
                    end
                    "{": begin
                        w_idle_res.tk = TK_LBRACE;  w_idle_res.grp = GRP_BRACKET;
                    end
                    "}": begin
                        w_idle_res.tk = TK_RBRACE;  w_idle_res.grp = GRP_BRACKET;
                    end
                    "[": begin
                        w_idle_res.tk = TK_LBRACK;  w_idle_res.grp = GRP_BRACKET;
                    end
                    "]": begin
                        w_idle_res.tk = TK_RBRACK;  w_idle_res.grp = GRP_BRACKET;
                    end
                    "=": begin
                        w_idle_res.tk = TK_ASSIGN;  w_idle_res.grp = GRP_ASSIGN;
                    end
                    ".": begin
                        w_idle_res.tk = TK_DOT;     w_idle_res.grp = GRP_PUNCT;
                    end
                    "%": begin
                        w_idle_res.tk = TK_PERCENT; w_idle_res.grp = GRP_BINOP;
                    end
                    ";": begin
                        w_idle_res.tk = TK_SEMI;    w_idle_res.grp = GRP_PUNCT;
                    end
                    ":": begin
                        w_idle_res.tk = TK_COLON;   w_idle_res.grp = GRP_PUNCT;
                    end
                    ",": begin
                        w_idle_res.tk = TK_COMMA;   w_idle_res.grp = GRP_PUNCT;
                    end
                    default: begin
                        w_idle_res = mk_err(ERR_UNKNOWN, w_here24, r_line, LEN_W'(1));
                        w_stop     = 1'b1;
                    end
                endcase
                w_idle_res.sym = 1'b0;
            end
        end
    end

    assign o_push       = i_accept && !r_halted && (w_back || w_p1_emit || w_idle_emit);
    assign o_run.two    = w_back && w_idle_emit;
    assign o_run.first  = w_back ? w_back_res : (w_p1_emit ? w_p1_res : w_idle_res);
    assign o_run.second = w_idle_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_offset <= '0;
            r_start  <= '0;
            r_line   <= '0;
            r_halted <= 1'b0;
        end else if (i_accept) begin
            r_offset <= r_offset + OFFSET_BITS'(1);
            if (!r_halted) begin
                r_state  <= n_state;
                r_halted <= w_stop;
                if (w_idle && i_char != 8'h00) begin
                    r_start <= r_offset;
                    if (i_char == "\n" && r_line != {LINE_W{1'b1}}) begin
                        r_line <= r_line + LINE_W'(1);
                    end
                end
            end
        end
    end

    // first bytes of the open token, for keyword and directive compare
    always_ff @(posedge i_clk) begin
        if (i_accept && !r_halted) begin
            if (w_idle) begin
                r_wbuf[0] <= i_char;
            end else if (w_keep && w_delta < OFFSET_BITS'(WORD_BUFFER_DEPTH)) begin
                r_wbuf[w_delta[IW-1:0]] <= i_char;
            end
        end
    end

endmodule

### rtl/stt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_back: result output stage
// Splits each run into single result beats behind an output register.
// ----------------------------------------------------------------------------
module stt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stt_pkg::t_run    i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output stt_pkg::t_result o_res,
    output logic             o_last
);
    import stt_pkg::*;

    logic    r_valid;
    logic    r_sel;
    logic    r_last;
    t_result r_res;
    logic    w_take;
    logic    w_last;

    assign w_take  = !r_valid || i_ready;
    assign w_last  = r_sel || !i_head.two;
    assign o_pop   = w_take && i_head_valid && w_last;
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (w_take) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_sel <= !w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_head_valid) begin
            r_res  <= r_sel ? i_head.second : i_head.first;
            r_last <= w_last;
        end
    end

endmodule
